[hdl/rhs_pkg.sv]
// Shared types, constants and table functions for the reverse heading scanner.
package rhs_pkg;

    localparam int OFFSET_BITS = 32;
    localparam int LENGTH_BITS = 16;
    localparam int NUM_STATES  = 27;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

    typedef logic [4:0] state_t;

    localparam state_t ST_IDLE       = 5'd0;
    localparam state_t ST_LF         = 5'd1;
    localparam state_t ST_CR1        = 5'd2;
    localparam state_t ST_AFTER_CR   = 5'd3;
    localparam state_t ST_AFTER_SP   = 5'd4;
    localparam state_t ST_BBB3       = 5'd5;
    localparam state_t ST_TIME_FIRST = 5'd6;
    localparam state_t ST_TIME_LAST  = 5'd11;
    localparam state_t ST_BBB2       = 5'd12;
    localparam state_t ST_BBB1       = 5'd13;
    localparam state_t ST_CCCC_FIRST = 5'd15;
    localparam state_t ST_CCCC_LAST  = 5'd18;
    localparam state_t ST_GAP_II     = 5'd19;
    localparam state_t ST_II_LO      = 5'd20;
    localparam state_t ST_II_HI      = 5'd21;
    localparam state_t ST_TTAA_FIRST = 5'd22;
    localparam state_t ST_END        = 5'd25;

    typedef enum logic [2:0] {
        CLS_NL,
        CLS_CR,
        CLS_SP,
        CLS_DIG,
        CLS_ALPHA,
        CLS_OTHER
    } cls_t;

    localparam state_t SP_NEXT [NUM_STATES] = '{
        5'd0, 5'd0, 5'd0, 5'd4, 5'd4, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd14, 5'd0,
        5'd26, 5'd14, 5'd0, 5'd0, 5'd0, 5'd19, 5'd19, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0,
        5'd0, 5'd26
    };

    localparam state_t DIG_NEXT [NUM_STATES] = '{
        5'd0, 5'd0, 5'd0, 5'd6, 5'd6, 5'd0, 5'd7, 5'd8, 5'd9, 5'd10, 5'd11, 5'd0, 5'd0,
        5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd20, 5'd21, 5'd0, 5'd0, 5'd0, 5'd0,
        5'd0, 5'd6
    };

    localparam state_t ALPHA_NEXT [NUM_STATES] = '{
        5'd0, 5'd0, 5'd0, 5'd5, 5'd5, 5'd12, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd13,
        5'd0, 5'd15, 5'd16, 5'd17, 5'd18, 5'd0, 5'd22, 5'd0, 5'd22, 5'd23, 5'd24,
        5'd25, 5'd0, 5'd0
    };

    typedef struct packed {
        logic [31:0] ttaa;
        logic [6:0]  bulletin_number;
        logic [31:0] centre;
        logic [6:0]  day;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [23:0] bbb;
        logic        has_bbb;
        logic        no_ii;
        logic [15:0] heading_len;
        logic [31:0] match_offset;
    } result_t;

    function automatic cls_t classify(input logic [7:0] b);
        cls_t c;
        if (b == 8'd10)
            c = CLS_NL;
        else if (b == 8'd13)
            c = CLS_CR;
        else if (b == 8'd32 || b == 8'd9)
            c = CLS_SP;
        else if (b >= 8'd48 && b <= 8'd57)
            c = CLS_DIG;
        else if ((b >= 8'd65 && b <= 8'd90) || (b >= 8'd97 && b <= 8'd122))
            c = CLS_ALPHA;
        else
            c = CLS_OTHER;
        return c;
    endfunction

    function automatic state_t scan_transition(input cls_t c, input state_t cur);
        state_t s;
        state_t n;
        // A state code beyond the table behaves as idle.
        s = (cur < state_t'(NUM_STATES)) ? cur : ST_IDLE;
        unique case (c)
            CLS_NL:    n = ST_LF;
            CLS_CR:    n = (s == ST_LF) ? ST_CR1 : ((s == ST_CR1) ? ST_AFTER_CR : ST_IDLE);
            CLS_SP:    n = SP_NEXT[s];
            CLS_DIG:   n = DIG_NEXT[s];
            CLS_ALPHA: n = ALPHA_NEXT[s];
            default:   n = ST_IDLE;
        endcase
        return n;
    endfunction

    // Tens digit in the upper byte; anything that is not a digit pair gives 0.
    function automatic logic [6:0] decode_pair(input logic [15:0] v);
        logic [6:0] r;
        if (v[15:8] < 8'd48 || v[15:8] > 8'd57 || v[7:0] < 8'd48 || v[7:0] > 8'd57)
            r = 7'd0;
        else
            r = {3'b000, v[11:8]} * 7'd10 + {3'b000, v[3:0]};
        return r;
    endfunction

endpackage

[hdl/rhs_scan_core.sv]
// Heading automaton: scan state, field capture, length and position counters.
module rhs_scan_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          data_byte,
    input  logic                restart,
    output logic                hit,
    output rhs_pkg::result_t    result
);

    rhs_pkg::state_t                     state_reg, state_next;
    logic [rhs_pkg::LENGTH_BITS-1:0]     len_reg, len_next;
    logic [rhs_pkg::OFFSET_BITS-1:0]     pos_reg, pos_next;
    logic [31:0]                         ttaa_reg, ttaa_next;
    logic [15:0]                         ii_reg, ii_next;
    logic [31:0]                         centre_reg, centre_next;
    logic [47:0]                         time_reg, time_next;
    logic [23:0]                         bbb_reg, bbb_next;
    logic                                bbb_seen_reg, bbb_seen_next;
    logic                                ii_missing_reg, ii_missing_next;

    rhs_pkg::cls_t                       cls;
    rhs_pkg::state_t                     cur;
    rhs_pkg::state_t                     nxt;
    logic [rhs_pkg::LENGTH_BITS-1:0]     len_base;
    logic [rhs_pkg::OFFSET_BITS-1:0]     pos_base;

    always_comb
    begin
        cls = rhs_pkg::classify(data_byte);

        // A restart clears everything before this byte is looked at.
        if (restart)
        begin
            cur             = rhs_pkg::ST_IDLE;
            len_base        = '0;
            pos_base        = '0;
            ttaa_next       = '0;
            ii_next         = '0;
            centre_next     = '0;
            time_next       = '0;
            bbb_next        = '0;
            bbb_seen_next   = 1'b0;
            ii_missing_next = 1'b0;
        end
        else
        begin
            cur             = state_reg;
            len_base        = len_reg;
            pos_base        = pos_reg;
            ttaa_next       = ttaa_reg;
            ii_next         = ii_reg;
            centre_next     = centre_reg;
            time_next       = time_reg;
            bbb_next        = bbb_reg;
            bbb_seen_next   = bbb_seen_reg;
            ii_missing_next = ii_missing_reg;
        end

        nxt      = rhs_pkg::scan_transition(cls, cur);
        pos_next = pos_base + rhs_pkg::OFFSET_BITS'(1);

        // A newline always opens a fresh match.
        if (cls == rhs_pkg::CLS_NL)
        begin
            ttaa_next       = '0;
            ii_next         = '0;
            centre_next     = '0;
            time_next       = '0;
            bbb_next        = '0;
            bbb_seen_next   = 1'b0;
            ii_missing_next = 1'b0;
            len_next        = rhs_pkg::LENGTH_BITS'(1);
        end
        else if (len_base != rhs_pkg::LEN_MAX)
            len_next = len_base + rhs_pkg::LENGTH_BITS'(1);
        else
            len_next = len_base;

        if (nxt == rhs_pkg::ST_BBB3
            && (cur == rhs_pkg::ST_AFTER_CR || cur == rhs_pkg::ST_AFTER_SP))
            bbb_seen_next = 1'b1;
        if (nxt == rhs_pkg::ST_TTAA_FIRST && cur == rhs_pkg::ST_GAP_II)
            ii_missing_next = 1'b1;

        if (nxt >= rhs_pkg::ST_TTAA_FIRST && nxt <= rhs_pkg::ST_END)
            ttaa_next[{2'(nxt - rhs_pkg::ST_TTAA_FIRST), 3'b000} +: 8] = data_byte;
        else if (nxt == rhs_pkg::ST_II_LO || nxt == rhs_pkg::ST_II_HI)
            ii_next[{1'(nxt - rhs_pkg::ST_II_LO), 3'b000} +: 8] = data_byte;
        else if (nxt >= rhs_pkg::ST_CCCC_FIRST && nxt <= rhs_pkg::ST_CCCC_LAST)
            centre_next[{2'(nxt - rhs_pkg::ST_CCCC_FIRST), 3'b000} +: 8] = data_byte;
        else if (nxt >= rhs_pkg::ST_TIME_FIRST && nxt <= rhs_pkg::ST_TIME_LAST)
            time_next[{3'(nxt - rhs_pkg::ST_TIME_FIRST), 3'b000} +: 8] = data_byte;
        else if (nxt == rhs_pkg::ST_BBB3)
            bbb_next[7:0] = data_byte;
        else if (nxt == rhs_pkg::ST_BBB2)
            bbb_next[15:8] = data_byte;
        else if (nxt == rhs_pkg::ST_BBB1)
            bbb_next[23:16] = data_byte;

        hit = (nxt == rhs_pkg::ST_END);
        state_next = hit ? rhs_pkg::ST_IDLE : nxt;

        result.ttaa            = ttaa_next;
        result.bulletin_number = rhs_pkg::decode_pair(ii_next);
        result.centre          = centre_next;
        result.day             = rhs_pkg::decode_pair(time_next[47:32]);
        result.hour            = rhs_pkg::decode_pair(time_next[31:16]);
        result.minute          = rhs_pkg::decode_pair(time_next[15:0]);
        result.bbb             = bbb_next;
        result.has_bbb         = bbb_seen_next;
        result.no_ii           = ii_missing_next;
        result.heading_len     = 16'(len_next);
        result.match_offset    = 32'(pos_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rhs_pkg::ST_IDLE;
            len_reg        <= '0;
            pos_reg        <= '0;
            ttaa_reg       <= '0;
            ii_reg         <= '0;
            centre_reg     <= '0;
            time_reg       <= '0;
            bbb_reg        <= '0;
            bbb_seen_reg   <= 1'b0;
            ii_missing_reg <= 1'b0;
        end
        else if (step)
        begin
            state_reg      <= state_next;
            len_reg        <= len_next;
            pos_reg        <= pos_next;
            ttaa_reg       <= ttaa_next;
            ii_reg         <= ii_next;
            centre_reg     <= centre_next;
            time_reg       <= time_next;
            bbb_reg        <= bbb_next;
            bbb_seen_reg   <= bbb_seen_next;
            ii_missing_reg <= ii_missing_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_state_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg < rhs_pkg::state_t'(rhs_pkg::NUM_STATES))
        else $error("scan state left the transition table");

    a_len_nonzero_in_match: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != rhs_pkg::ST_IDLE |-> len_reg != '0)
        else $error("active match with zero heading length");
`endif

endmodule

[hdl/reverse_heading_scanner.sv]
// The final byte of a heading is held in the input register; the result register loads
// when the automaton steps that byte, and out_valid is registered with it.
// Throughput: one byte per cycle; the byte register holds only when its byte
// completes a heading while the result register is full and not being taken.
// The input register, the automaton step and the result register form the path.
// Reset (rst_n low, asynchronous) sets the automaton idle with its capture fields zero.
module reverse_heading_scanner (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        restart,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] ttaa,
    output logic [6:0]  bulletin_number,
    output logic [31:0] centre,
    output logic [6:0]  day,
    output logic [6:0]  hour,
    output logic [6:0]  minute,
    output logic [23:0] bbb,
    output logic        has_bbb,
    output logic        no_ii,
    output logic [15:0] heading_len,
    output logic [31:0] match_offset
);

    logic              stage_valid_reg;
    logic [7:0]        byte_reg;
    logic              restart_reg;
    logic              out_valid_reg;
    rhs_pkg::result_t  result_reg;

    logic              hit;
    rhs_pkg::result_t  result;
    logic              advance;

    // The staged byte moves on unless its result has nowhere to go.
    assign advance  = !(hit && out_valid_reg && !out_ready);
    assign in_ready = !stage_valid_reg || advance;

    rhs_scan_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (stage_valid_reg && advance),
        .data_byte (byte_reg),
        .restart   (restart_reg),
        .hit       (hit),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_ready)
                stage_valid_reg <= in_valid;
            if (stage_valid_reg && advance && hit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg    <= data_byte;
            restart_reg <= restart;
        end
        if (stage_valid_reg && advance && hit)
            result_reg <= result;
    end

    assign out_valid       = out_valid_reg;
    assign ttaa            = result_reg.ttaa;
    assign bulletin_number = result_reg.bulletin_number;
    assign centre          = result_reg.centre;
    assign day             = result_reg.day;
    assign hour            = result_reg.hour;
    assign minute          = result_reg.minute;
    assign bbb             = result_reg.bbb;
    assign has_bbb         = result_reg.has_bbb;
    assign no_ii           = result_reg.no_ii;
    assign heading_len     = result_reg.heading_len;
    assign match_offset    = result_reg.match_offset;

`ifndef NO_ASSERTIONS
    a_hit_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg && advance && hit |=> out_valid_reg)
        else $error("completed heading did not reach the result register");

    a_decoded_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> bulletin_number <= 7'd99 && day <= 7'd99
                          && hour <= 7'd99 && minute <= 7'd99)
        else $error("decoded digit pair out of range");

    a_no_ii_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && no_ii |-> bulletin_number == 7'd0)
        else $error("bulletin number present although ii is absent");

    a_bbb_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !has_bbb |-> bbb == 24'd0)
        else $error("BBB bytes captured without the BBB flag");
`endif

endmodule
